FILE: hw/rtl/ctt_pkg.sv
// Shared types, codes and character classes for the configuration text tokenizer.
package ctt_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 3;
  localparam int MAX_RESULTS = 3;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_IDENT  = 3'd1,
    MODE_INT    = 3'd2,
    MODE_FLOAT  = 3'd3,
    MODE_MINUS  = 3'd4,
    MODE_STRING = 3'd5
  } lexer_mode_t;

  localparam logic [3:0] TOK_NONE   = 4'd0;
  localparam logic [3:0] TOK_END    = 4'd1;
  localparam logic [3:0] TOK_IDENT  = 4'd2;
  localparam logic [3:0] TOK_INT    = 4'd3;
  localparam logic [3:0] TOK_FLOAT  = 4'd4;
  localparam logic [3:0] TOK_STRING = 4'd5;
  localparam logic [3:0] TOK_LT     = 4'd6;
  localparam logic [3:0] TOK_GT     = 4'd7;
  localparam logic [3:0] TOK_LBRACE = 4'd8;
  localparam logic [3:0] TOK_RBRACE = 4'd9;
  localparam logic [3:0] TOK_LBRACK = 4'd10;
  localparam logic [3:0] TOK_RBRACK = 4'd11;
  localparam logic [3:0] TOK_COLON  = 4'd12;
  localparam logic [3:0] TOK_COMMA  = 4'd13;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef struct packed {
    logic [7:0] ch;
    logic [3:0] kind;
    logic       close;
    logic       unterm;
  } result_t;

  // All results caused by one input character, first result in res[0].
  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [1:0]                count;
  } bundle_t;

  function automatic result_t mk_result(input logic [7:0] ch, input logic [3:0] kind,
                                        input logic close, input logic unterm);
    result_t r;
    r.ch     = ch;
    r.kind   = kind;
    r.close  = close;
    r.unterm = unterm;
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

endpackage

FILE: hw/rtl/ctt_lexer.sv
// Input register, lexer mode register and the decode of one character into its results.
module ctt_lexer
  import ctt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] char_code,
  output logic       busy,
  output logic       push,
  output bundle_t    bundle
);

  logic        in_valid;
  logic [7:0]  in_char;
  lexer_mode_t mode;
  lexer_mode_t mode_next;

  logic [1:0]  idle_cnt;
  result_t     idle_r0;
  result_t     idle_r1;
  lexer_mode_t idle_mode;
  logic        punct_hit;
  logic [3:0]  punct_kind;

  logic        use_idle;
  logic        has_prefix;
  result_t     prefix;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      mode     <= MODE_IDLE;
    end else begin
      in_valid <= accept;
      if (in_valid) begin
        mode <= mode_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_char <= char_code;
    end
  end

  always_comb begin
    punct_hit  = 1'b1;
    punct_kind = TOK_NONE;
    case (in_char)
      CH_LT:     punct_kind = TOK_LT;
      CH_GT:     punct_kind = TOK_GT;
      CH_LBRACE: punct_kind = TOK_LBRACE;
      CH_RBRACE: punct_kind = TOK_RBRACE;
      CH_LBRACK: punct_kind = TOK_LBRACK;
      CH_RBRACK: punct_kind = TOK_RBRACK;
      CH_COLON:  punct_kind = TOK_COLON;
      CH_COMMA:  punct_kind = TOK_COMMA;
      default:   punct_hit  = 1'b0;
    endcase
  end

  // Handling of the character as if no token were open.
  always_comb begin
    idle_cnt  = 2'd0;
    idle_r0   = '0;
    idle_r1   = '0;
    idle_mode = MODE_IDLE;
    if (is_space(in_char)) begin
      idle_cnt = 2'd0;
    end else if (is_alpha(in_char) || (in_char == CH_UNDER)) begin
      idle_mode = MODE_IDENT;
      idle_cnt  = 2'd1;
      idle_r0   = mk_result(in_char, TOK_IDENT, 1'b0, 1'b0);
    end else if (is_digit(in_char)) begin
      idle_mode = MODE_INT;
      idle_cnt  = 2'd1;
      idle_r0   = mk_result(in_char, TOK_INT, 1'b0, 1'b0);
    end else if (in_char == CH_NUL) begin
      idle_cnt = 2'd1;
      idle_r0  = mk_result(CH_NUL, TOK_END, 1'b1, 1'b0);
    end else if (in_char == CH_MINUS) begin
      idle_mode = MODE_MINUS;
    end else if (in_char == CH_QUOTE) begin
      idle_mode = MODE_STRING;
    end else if (punct_hit) begin
      idle_cnt = 2'd2;
      idle_r0  = mk_result(in_char, punct_kind, 1'b0, 1'b0);
      idle_r1  = mk_result(CH_NUL, punct_kind, 1'b1, 1'b0);
    end else begin
      idle_cnt = 2'd1;
      idle_r0  = mk_result(CH_NUL, TOK_NONE, 1'b1, 1'b0);
    end
  end

  always_comb begin
    bundle     = '0;
    mode_next  = mode;
    use_idle   = 1'b0;
    has_prefix = 1'b0;
    prefix     = '0;
    case (mode)
      MODE_IDENT: begin
        if (is_alpha(in_char) || is_digit(in_char) || (in_char == CH_UNDER)) begin
          bundle.res[0] = mk_result(in_char, TOK_IDENT, 1'b0, 1'b0);
          bundle.count  = 2'd1;
        end else begin
          use_idle   = 1'b1;
          has_prefix = 1'b1;
          prefix     = mk_result(CH_NUL, TOK_IDENT, 1'b1, 1'b0);
        end
      end
      MODE_INT, MODE_FLOAT: begin
        if (is_digit(in_char) || (in_char == CH_DOT)) begin
          if ((in_char == CH_DOT) || (mode == MODE_FLOAT)) begin
            mode_next     = MODE_FLOAT;
            bundle.res[0] = mk_result(in_char, TOK_FLOAT, 1'b0, 1'b0);
          end else begin
            bundle.res[0] = mk_result(in_char, TOK_INT, 1'b0, 1'b0);
          end
          bundle.count = 2'd1;
        end else begin
          use_idle   = 1'b1;
          has_prefix = 1'b1;
          prefix     = mk_result(CH_NUL, (mode == MODE_FLOAT) ? TOK_FLOAT : TOK_INT,
                                 1'b1, 1'b0);
        end
      end
      MODE_MINUS: begin
        if (is_digit(in_char)) begin
          bundle.res[0] = mk_result(CH_MINUS, TOK_INT, 1'b0, 1'b0);
          bundle.res[1] = mk_result(in_char, TOK_INT, 1'b0, 1'b0);
          bundle.count  = 2'd2;
          mode_next     = MODE_INT;
        end else begin
          use_idle   = 1'b1;
          has_prefix = 1'b1;
          prefix     = mk_result(CH_NUL, TOK_NONE, 1'b1, 1'b0);
        end
      end
      MODE_STRING: begin
        if (in_char == CH_QUOTE) begin
          bundle.res[0] = mk_result(CH_NUL, TOK_STRING, 1'b1, 1'b0);
          bundle.count  = 2'd1;
          mode_next     = MODE_IDLE;
        end else if (in_char == CH_NUL) begin
          use_idle   = 1'b1;
          has_prefix = 1'b1;
          prefix     = mk_result(CH_NUL, TOK_STRING, 1'b1, 1'b1);
        end else begin
          bundle.res[0] = mk_result(in_char, TOK_STRING, 1'b0, 1'b0);
          bundle.count  = 2'd1;
        end
      end
      default: begin
        use_idle = 1'b1;
      end
    endcase

    // A token closed by a foreign character is followed by that character's own results.
    if (use_idle) begin
      mode_next = idle_mode;
      if (has_prefix) begin
        bundle.res[0] = prefix;
        bundle.res[1] = idle_r0;
        bundle.res[2] = idle_r1;
        bundle.count  = 2'd1 + idle_cnt;
      end else begin
        bundle.res[0] = idle_r0;
        bundle.res[1] = idle_r1;
        bundle.count  = idle_cnt;
      end
    end
  end

  assign busy = in_valid;
  assign push = in_valid && (bundle.count != 2'd0);

endmodule

FILE: hw/rtl/ctt_result_queue.sv
// Queue of result bundles and the serializer that hands out one result per handshake.
module ctt_result_queue
  import ctt_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bundle_t       bundle,
  output logic [CW-1:0] fill,
  output logic          token_valid,
  input  logic          token_stall,
  output logic [7:0]    token_char,
  output logic [3:0]    token_type,
  output logic          token_end,
  output logic          string_unterminated,
  output logic          last_result
);

  bundle_t       mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [1:0]    idx;
  bundle_t       head;
  result_t       cur;
  logic          last;
  logic          take;
  logic          pop;

  assign head        = mem[rd_ptr];
  assign cur         = head.res[idx];
  assign last        = (idx == (head.count - 2'd1));
  assign token_valid = (fill != '0);
  assign take        = token_valid && !token_stall;
  assign pop         = take && last;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
      idx    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
      if (take) begin
        idx <= last ? 2'd0 : idx + 2'd1;
      end
    end
  end

  assign token_char          = cur.ch;
  assign token_type          = cur.kind;
  assign token_end           = cur.close;
  assign string_unterminated = cur.unterm;
  assign last_result         = last;

endmodule

FILE: hw/rtl/config_text_tokenizer.sv
// Top level of the streaming configuration text tokenizer.
//
// Input channel: one ASCII character per item on char_code, moved when
// char_valid is high and char_stall is low. Output channel: one result per
// item (token_char, token_type, token_end, string_unterminated,
// last_result), moved when token_valid is high and token_stall is low.
// Each character causes zero to three results; last_result marks the final
// one caused by a character. Whitespace, an opening quote and a minus give
// no result when they arrive while no token is open.
// A character passes through the input register and then the result queue
// before its first result reaches the port. Throughput: one character per
// cycle while each character gives at most one result and the receiver does
// not stall; a character with several results occupies the output port for
// one handshake per result, which sets the rate.
// A small queue of result bundles sits between the lexer and the port, so
// characters keep being accepted while results wait. When the receiver
// stalls, the queue fills and char_stall rises until room is free again.
// Reset clears the lexer mode to idle and empties the queue; char_stall is
// high during reset.
module config_text_tokenizer
  import ctt_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  logic [7:0] char_code,
  output logic       token_valid,
  input  logic       token_stall,
  output logic [7:0] token_char,
  output logic [3:0] token_type,
  output logic       token_end,
  output logic       string_unterminated,
  output logic       last_result
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic          accept;
  logic          busy;
  logic          push;
  bundle_t       bundle;
  logic [CW-1:0] fill;
  logic [CW:0]   committed;

  // Room must remain for the character already in the input register.
  assign committed  = {1'b0, fill} + (CW + 1)'(busy);
  assign char_stall = rst || (committed >= (CW + 1)'(QUEUE_DEPTH));
  assign accept     = char_valid && !char_stall;

  ctt_lexer u_lexer (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_code (char_code),
    .busy      (busy),
    .push      (push),
    .bundle    (bundle)
  );

  ctt_result_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk                 (clk),
    .rst                 (rst),
    .push                (push),
    .bundle              (bundle),
    .fill                (fill),
    .token_valid         (token_valid),
    .token_stall         (token_stall),
    .token_char          (token_char),
    .token_type          (token_type),
    .token_end           (token_end),
    .string_unterminated (string_unterminated),
    .last_result         (last_result)
  );

endmodule

FILE: hw/rtl/ctt_checker.sv
// Port-level checks for the tokenizer, attached to the top level by bind.
module ctt_checker
  import ctt_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       token_valid,
  input logic       token_stall,
  input logic [7:0] token_char,
  input logic [3:0] token_type,
  input logic       token_end,
  input logic       string_unterminated,
  input logic       last_result
);

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (rst)
    token_valid && token_stall |=> token_valid)
    else $error("result withdrawn while stalled");

  // A stalled result does not change.
  assert property (@(posedge clk) disable iff (rst)
    token_valid && token_stall |=>
      $stable(token_char) && $stable(token_type) && $stable(token_end) &&
      $stable(string_unterminated) && $stable(last_result))
    else $error("result changed while stalled");

  // Closing results carry no character, and character results always carry one.
  assert property (@(posedge clk) disable iff (rst)
    token_valid |-> (token_end == (token_char == CH_NUL)))
    else $error("closing flag and character disagree");

  // A cut-off string result closes a string and is not the last result for its character.
  assert property (@(posedge clk) disable iff (rst)
    token_valid && string_unterminated |->
      token_end && (token_type == TOK_STRING) && !last_result)
    else $error("unterminated string result malformed");

  // The end token is a closing result and the last one for its character.
  assert property (@(posedge clk) disable iff (rst)
    token_valid && (token_type == TOK_END) |-> token_end && last_result)
    else $error("end token malformed");

endmodule

bind config_text_tokenizer ctt_checker u_ctt_checker (
  .clk                 (clk),
  .rst                 (rst),
  .token_valid         (token_valid),
  .token_stall         (token_stall),
  .token_char          (token_char),
  .token_type          (token_type),
  .token_end           (token_end),
  .string_unterminated (string_unterminated),
  .last_result         (last_result)
);
